// ----- src/pal_pkg.sv -----
`default_nettype none

package pal_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int POS_W  = 4;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CAP_W  = 5;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    localparam logic [0:0] REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

// ----- src/pal_ram.sv -----
`default_nettype none

module pal_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/pal_ctrl.sv -----
`default_nettype none

module pal_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [pal_pkg::CAP_W-1:0]    capacity,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [pal_pkg::CMD_W-1:0]    cmd,
    input  wire logic [pal_pkg::POS_W-1:0]    position,
    input  wire logic [pal_pkg::DATA_W-1:0]   value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [pal_pkg::STAT_W-1:0]        status,
    output logic [pal_pkg::DATA_W-1:0]        data_out,
    output logic [pal_pkg::CNT_W-1:0]         entry_count,
    output pal_pkg::ram_req_t                 ram_req,
    input  wire logic [pal_pkg::DATA_W-1:0]   ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_RD0,
        S_CAP,
        S_DEL_RD,
        S_DEL_WR,
        S_DONE
    } state_t;

    state_t                       state_reg;
    pal_pkg::cmd_t                cmd_reg;
    logic [pal_pkg::CNT_W-1:0]    pos_reg;
    logic [pal_pkg::DATA_W-1:0]   val_reg;
    logic [pal_pkg::CNT_W-1:0]    idx_reg;
    logic [pal_pkg::CNT_W-1:0]    count_reg;
    pal_pkg::status_t             stat_reg;
    logic [pal_pkg::DATA_W-1:0]   data_reg;
    logic                         out_valid_reg;
    logic [pal_pkg::STAT_W-1:0]   status_reg;
    logic [pal_pkg::DATA_W-1:0]   data_out_reg;
    logic [pal_pkg::CNT_W-1:0]    entry_count_reg;

    logic [pal_pkg::CNT_W-1:0]    eff_cap;
    logic [pal_pkg::CNT_W-1:0]    in_pos;
    logic [pal_pkg::CNT_W-1:0]    idx_dec;
    logic [pal_pkg::CNT_W-1:0]    pos_inc;

    assign eff_cap = (capacity > pal_pkg::CAP_W'(pal_pkg::DEPTH))
                     ? pal_pkg::CNT_W'(pal_pkg::DEPTH) : pal_pkg::CNT_W'(capacity);
    assign in_pos  = pal_pkg::CNT_W'(position);
    assign idx_dec = idx_reg - pal_pkg::CNT_W'(1);
    assign pos_inc = pos_reg + pal_pkg::CNT_W'(1);

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign data_out    = data_out_reg;
    assign entry_count = entry_count_reg;

    // one RAM port pair; each entry move is a read then a write
    always_comb
    begin
        ram_req = '0;
        case (state_reg)
            S_INS_RD:
            begin
                if (idx_reg > pos_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_dec[pal_pkg::ADDR_W-1:0];
                end
                else
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = pos_reg[pal_pkg::ADDR_W-1:0];
                    ram_req.wdata = val_reg;
                end
            end
            S_INS_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_reg[pal_pkg::ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
            end
            S_RD0:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = pos_reg[pal_pkg::ADDR_W-1:0];
            end
            S_DEL_RD:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = idx_reg[pal_pkg::ADDR_W-1:0];
                end
            end
            S_DEL_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = idx_dec[pal_pkg::ADDR_W-1:0];
                ram_req.wdata = ram_rdata;
            end
            default:
            begin
                ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_reg         <= pal_pkg::CMD_INSERT;
            pos_reg         <= '0;
            val_reg         <= '0;
            idx_reg         <= '0;
            count_reg       <= '0;
            stat_reg        <= pal_pkg::ST_OK;
            data_reg        <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= '0;
            data_out_reg    <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg  <= pal_pkg::cmd_t'(cmd);
                        val_reg  <= value;
                        data_reg <= '0;
                        case (pal_pkg::cmd_t'(cmd))
                            pal_pkg::CMD_INSERT:
                            begin
                                if (count_reg >= eff_cap)
                                begin
                                    stat_reg  <= pal_pkg::ST_FULL;
                                    pos_reg   <= in_pos;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    stat_reg  <= pal_pkg::ST_OK;
                                    pos_reg   <= (in_pos > count_reg) ? count_reg : in_pos;
                                    idx_reg   <= count_reg;
                                    state_reg <= S_INS_RD;
                                end
                            end
                            pal_pkg::CMD_DELETE, pal_pkg::CMD_GET:
                            begin
                                pos_reg <= in_pos;
                                if (in_pos >= count_reg ||
                                    in_pos >= pal_pkg::CNT_W'(pal_pkg::DEPTH))
                                begin
                                    stat_reg  <= pal_pkg::ST_RANGE;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    stat_reg  <= pal_pkg::ST_OK;
                                    state_reg <= S_RD0;
                                end
                            end
                            default:
                            begin
                                stat_reg  <= pal_pkg::ST_OK;
                                pos_reg   <= in_pos;
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INS_RD:
                begin
                    if (idx_reg > pos_reg)
                    begin
                        state_reg <= S_INS_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg + pal_pkg::CNT_W'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_INS_WR:
                begin
                    idx_reg   <= idx_dec;
                    state_reg <= S_INS_RD;
                end
                S_RD0:
                begin
                    state_reg <= S_CAP;
                end
                S_CAP:
                begin
                    data_reg <= ram_rdata;
                    idx_reg  <= pos_inc;
                    if (cmd_reg == pal_pkg::CMD_GET)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DEL_RD;
                    end
                end
                S_DEL_RD:
                begin
                    if (idx_reg < count_reg)
                    begin
                        state_reg <= S_DEL_WR;
                    end
                    else
                    begin
                        count_reg <= count_reg - pal_pkg::CNT_W'(1);
                        state_reg <= S_DONE;
                    end
                end
                S_DEL_WR:
                begin
                    idx_reg   <= idx_reg + pal_pkg::CNT_W'(1);
                    state_reg <= S_DEL_RD;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        status_reg      <= stat_reg;
                        data_out_reg    <= data_reg;
                        entry_count_reg <= count_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/positional_array_list_unit.sv -----
`default_nettype none

// Ordered list of up to list_capacity words held in a single-port-pair RAM
// (one write, one registered read per cycle). Requests are taken one at a
// time; a request may be taken while the previous result still waits in the
// output register. An insert at position p, clamped to the entry count,
// moves count - p entries up; a delete at position p moves count - p - 1
// entries down. Each entry moved takes a RAM read then its write-back.
// No clearing pass after reset. Capacity lives at byte address 0 (APB).

module positional_array_list_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [pal_pkg::CMD_W-1:0]     cmd,
    input  wire logic [pal_pkg::POS_W-1:0]     position,
    input  wire logic [pal_pkg::DATA_W-1:0]    value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [pal_pkg::STAT_W-1:0]         status,
    output logic [pal_pkg::DATA_W-1:0]         data_out,
    output logic [pal_pkg::CNT_W-1:0]          entry_count,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pal_pkg::APB_AW-1:0]    paddr,
    input  wire logic [pal_pkg::APB_DW-1:0]    pwdata,
    output logic [pal_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    logic [pal_pkg::CAP_W-1:0]  cap_reg;
    logic [pal_pkg::DATA_W-1:0] ram_rdata;
    pal_pkg::ram_req_t          ram_req;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pal_pkg::REG_CAPACITY)
                    ? pal_pkg::APB_DW'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= pal_pkg::CAP_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == pal_pkg::REG_CAPACITY)
        begin
            cap_reg <= pwdata[pal_pkg::CAP_W-1:0];
        end
    end

    pal_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (cap_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .data_out    (data_out),
        .entry_count (entry_count),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    pal_ram #(
        .DEPTH (pal_pkg::DEPTH),
        .WIDTH (pal_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- src/pal_checker.sv -----
`default_nettype none

module pal_checker (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic [pal_pkg::STAT_W-1:0] status,
    input  wire logic [pal_pkg::DATA_W-1:0] data_out,
    input  wire logic [pal_pkg::CNT_W-1:0]  entry_count
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out) && $stable(status))
        else $error("result dropped or changed under stall");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= pal_pkg::CNT_W'(pal_pkg::DEPTH))
        else $error("entry count above depth");

    a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == pal_pkg::ST_FULL || status == pal_pkg::ST_RANGE)
        |-> data_out == '0)
        else $error("error result carries data");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(entry_count))
        else $error("entry count changed under stall");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == pal_pkg::ST_OK || status == pal_pkg::ST_FULL ||
        status == pal_pkg::ST_RANGE)
        else $error("undefined status code");

endmodule

bind positional_array_list_unit pal_checker u_pal_checker (.*);

`default_nettype wire
